@@ hdl/pgc_pkg.sv @@
// pgc_pkg: constants, item types and saturation value for the peak/gain calibration core.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pgc_pkg;

   localparam int NUM_CHANNELS_DEF = 4;   // default channel count of the core
   localparam int IN_CHANNELS      = 4;   // sample fields carried by one input item
   localparam int TOP_COUNT        = 4;   // peaks kept per channel
   localparam int SAMPLE_BITS      = 12;
   localparam int POS_BITS         = 12;
   localparam int CH_IDX_BITS      = 2;
   localparam int GAIN_SHIFT       = 10;
   localparam int AVG_SHIFT        = 2;   // log2 of TOP_COUNT
   localparam int SUM_BITS         = SAMPLE_BITS + AVG_SHIFT;
   localparam int GAIN_BITS        = SAMPLE_BITS + GAIN_SHIFT;

   // gain reported for a channel whose average is zero
   localparam logic [GAIN_BITS-1:0] GAIN_SAT =
      GAIN_BITS'(((1 << SAMPLE_BITS) - 1) << GAIN_SHIFT);

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_ch0;
      logic [SAMPLE_BITS-1:0] sample_ch1;
      logic [SAMPLE_BITS-1:0] sample_ch2;
      logic [SAMPLE_BITS-1:0] sample_ch3;
      logic [POS_BITS-1:0]    sweep_position;
      logic                   end_of_sweep;
   } req_item_type;

   typedef struct packed {
      logic [CH_IDX_BITS-1:0] channel_index;
      logic [SAMPLE_BITS-1:0] average_peak;
      logic [POS_BITS-1:0]    best_position;
      logic [GAIN_BITS-1:0]   norm_gain;
      logic                   zero_peak;
      logic                   last_result;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hdl/pgc_if.sv @@
// pgc_if: valid/ready channel interfaces for sweep items (req) and channel results (rsp).
// Depends on pgc_pkg for the item types.
`default_nettype none

interface pgc_req_if import pgc_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pgc_rsp_if import pgc_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/top_peak_gain_calibration_core.sv @@
// top_peak_gain_calibration_core: per-channel top-four peak tracker with gain normalization.
// Depends on pgc_pkg, pgc_if (pgc_req_if, pgc_rsp_if) and pgc_divider.
//
//   channel  | dir | handshake            | item
//   ---------+-----+----------------------+------------------------------------------------
//   req_ch   | in  | valid/ready, sink    | four samples, sweep position, end-of-sweep flag
//   rsp_ch   | out | valid/ready, source  | one channel: average, best position, gain, flags
//
// A sweep item without the end flag is inserted and leaves the core idle; ready stays high while idle.
// An end item is inserted, then ST_AVG averages each channel and finds the reference; then per
// channel ST_START sets up the result, ST_DIV runs the serial divider when the average is nonzero,
// and ST_OUT holds the result until it is taken.
// Reset (synchronous) clears the peak tables and returns to idle; the tables clear again
// when the last channel's result is taken. A stalled result simply holds the sequencer.
`default_nettype none

module top_peak_gain_calibration_core import pgc_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   pgc_req_if.sink   req_ch,
   pgc_rsp_if.source rsp_ch
);

   localparam int CH_BITS = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(NUM_CHANNELS - 1);

   // ST_AVG walks the channels for averages and the reference; ST_START/ST_DIV/ST_OUT
   // then walk them again for gain and output.
   typedef enum logic [2:0] {ST_IDLE, ST_AVG, ST_START, ST_DIV, ST_OUT} state_type;

   state_type              state_ff;
   logic [CH_BITS-1:0]     ch_ff;
   logic [SAMPLE_BITS-1:0] ref_ff;
   logic [SAMPLE_BITS-1:0] avg_ff [NUM_CHANNELS];
   rsp_item_type           rsp_ff;

   // kept peaks, descending per channel, with their sweep positions
   logic [SAMPLE_BITS-1:0] peak_val_ff [NUM_CHANNELS][TOP_COUNT];
   logic [POS_BITS-1:0]    peak_pos_ff [NUM_CHANNELS][TOP_COUNT];
   logic [SAMPLE_BITS-1:0] peak_val_in [NUM_CHANNELS][TOP_COUNT];
   logic [POS_BITS-1:0]    peak_pos_in [NUM_CHANNELS][TOP_COUNT];

   logic [SAMPLE_BITS-1:0] in_sample   [IN_CHANNELS];
   logic [SAMPLE_BITS-1:0] chan_sample [NUM_CHANNELS];
   logic [TOP_COUNT-1:0]   gt_w        [NUM_CHANNELS];

   logic [SUM_BITS-1:0]    sum_w;
   logic [SAMPLE_BITS-1:0] avg_w;
   logic                   req_fire;
   logic                   div_start;
   logic                   div_done;
   logic [GAIN_BITS-1:0]   div_quot;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_sample[0] = req_ch.payload.sample_ch0;
   assign in_sample[1] = req_ch.payload.sample_ch1;
   assign in_sample[2] = req_ch.payload.sample_ch2;
   assign in_sample[3] = req_ch.payload.sample_ch3;

   // channels beyond the carried samples see zero, which never enters a table
   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
      if (c < IN_CHANNELS) begin : g_live
         assign chan_sample[c] = in_sample[c];
      end else begin : g_idle
         assign chan_sample[c] = '0;
      end
   end

   // a sample enters at the first entry it strictly exceeds; gt_w is a suffix mask
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         for (int i = 0; i < TOP_COUNT; i++) begin
            gt_w[c][i] = chan_sample[c] > peak_val_ff[c][i];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (gt_w[c][0]) begin
            peak_val_in[c][0] = chan_sample[c];
            peak_pos_in[c][0] = req_ch.payload.sweep_position;
         end else begin
            peak_val_in[c][0] = peak_val_ff[c][0];
            peak_pos_in[c][0] = peak_pos_ff[c][0];
         end
         for (int i = 1; i < TOP_COUNT; i++) begin
            if (!gt_w[c][i]) begin
               peak_val_in[c][i] = peak_val_ff[c][i];
               peak_pos_in[c][i] = peak_pos_ff[c][i];
            end else if (!gt_w[c][i-1]) begin
               peak_val_in[c][i] = chan_sample[c];
               peak_pos_in[c][i] = req_ch.payload.sweep_position;
            end else begin
               peak_val_in[c][i] = peak_val_ff[c][i-1];
               peak_pos_in[c][i] = peak_pos_ff[c][i-1];
            end
         end
      end
   end

   // average of the selected channel: sum of the kept peaks, shifted down
   always_comb begin
      sum_w = '0;
      for (int i = 0; i < TOP_COUNT; i++) begin
         sum_w = sum_w + SUM_BITS'(peak_val_ff[ch_ff][i]);
      end
   end
   assign avg_w = sum_w[SUM_BITS-1:AVG_SHIFT];

   assign div_start = (state_ff == ST_START) && (avg_ff[ch_ff] != '0);

   pgc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({ref_ff, GAIN_SHIFT'(0)}),
      .divisor  (avg_ff[ch_ff]),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ch_ff       <= '0;
         peak_val_ff <= '{default: '0};
         peak_pos_ff <= '{default: '0};
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  peak_val_ff <= peak_val_in;
                  peak_pos_ff <= peak_pos_in;
                  if (req_ch.payload.end_of_sweep) begin
                     ref_ff   <= '0;
                     ch_ff    <= '0;
                     state_ff <= ST_AVG;
                  end
               end
            end
            ST_AVG: begin
               avg_ff[ch_ff] <= avg_w;
               if (avg_w > ref_ff) begin
                  ref_ff <= avg_w;
               end
               if (ch_ff == CH_LAST) begin
                  ch_ff    <= '0;
                  state_ff <= ST_START;
               end else begin
                  ch_ff <= ch_ff + 1'b1;
               end
            end
            ST_START: begin
               rsp_ff.channel_index <= CH_IDX_BITS'(ch_ff);
               rsp_ff.average_peak  <= avg_ff[ch_ff];
               rsp_ff.best_position <= peak_pos_ff[ch_ff][0];
               rsp_ff.last_result   <= (ch_ff == CH_LAST);
               if (avg_ff[ch_ff] == '0) begin
                  rsp_ff.norm_gain <= GAIN_SAT;
                  rsp_ff.zero_peak <= 1'b1;
                  state_ff         <= ST_OUT;
               end else begin
                  rsp_ff.zero_peak <= 1'b0;
                  state_ff         <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  rsp_ff.norm_gain <= div_quot;
                  state_ff         <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_ch.ready) begin
                  if (ch_ff == CH_LAST) begin
                     // run complete: tables back to empty for the next sweep
                     peak_val_ff <= '{default: '0};
                     peak_pos_ff <= '{default: '0};
                     ch_ff       <= '0;
                     state_ff    <= ST_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= ST_START;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid   = (state_ff == ST_OUT);
   assign rsp_ch.payload = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/pgc_divider.sv @@
// pgc_divider: restoring divider, one quotient bit per cycle, producing a GAIN_BITS-wide quotient.
// Depends on pgc_pkg for widths.
`default_nettype none

module pgc_divider import pgc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [GAIN_BITS-1:0]   dividend,
   input  wire logic [SAMPLE_BITS-1:0] divisor,
   output logic                        done,
   output logic [GAIN_BITS-1:0]        quotient
);

   localparam int CNT_BITS = $clog2(GAIN_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(GAIN_BITS - 1);

   typedef enum logic {DV_IDLE, DV_RUN} state_type;

   state_type              state_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [SAMPLE_BITS-1:0] rem_ff;
   logic [SAMPLE_BITS-1:0] dsr_ff;
   logic [GAIN_BITS-1:0]   quo_ff;
   logic                   done_ff;

   logic [SAMPLE_BITS:0]   trial_w;
   logic [SAMPLE_BITS:0]   diff_w;
   logic                   fits_w;
   logic [SAMPLE_BITS-1:0] rem_in;
   logic [GAIN_BITS-1:0]   quo_in;

   // quo_ff shifts the dividend out at the top and the quotient in at the bottom
   assign trial_w = {rem_ff, quo_ff[GAIN_BITS-1]};
   assign diff_w  = trial_w - {1'b0, dsr_ff};
   assign fits_w  = trial_w >= {1'b0, dsr_ff};
   assign rem_in  = fits_w ? diff_w[SAMPLE_BITS-1:0] : trial_w[SAMPLE_BITS-1:0];
   assign quo_in  = {quo_ff[GAIN_BITS-2:0], fits_w};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  rem_ff   <= '0;
                  quo_ff   <= dividend;
                  dsr_ff   <= divisor;
                  cnt_ff   <= '0;
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  done_ff  <= 1'b1;
                  state_ff <= DV_IDLE;
               end
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire
